[rtl/rclk_pkg.sv]
package rclk_pkg;

  // Field widths and clock face geometry.
  localparam int unsigned TIME_W  = 26;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned QUO_W   = 8;
  localparam int unsigned REM_W   = 34;

  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [QUO_W-1:0]   quo_t;
  typedef logic [REM_W-1:0]   rem_t;

  localparam pos_t   LAST_POS   = pos_t'(11);
  localparam level_t FULL_LEVEL = level_t'(255);

  // The time is scaled by 255/5000 * 1000 = 51 on entry, so the remainder left after the
  // five-second division is already 51 * t, ready for the division by 1000 that gives the
  // fade level. Every divisor ahead of that step is scaled by the same factor.
  localparam int unsigned SCALE = 51;
  localparam rem_t DIV_HOUR  = rem_t'(SCALE * 3600000);
  localparam rem_t DIV_MARK  = rem_t'(SCALE * 300000);
  localparam rem_t DIV_FIVE  = rem_t'(SCALE * 5000);
  localparam rem_t DIV_FADE  = rem_t'(1000);

  // Depth of the queue between the front and back parts.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // One classified time value, as handed from the front part to the back part.
  typedef struct packed {
    pos_t   hour;
    pos_t   mark;
    pos_t   lead;
    level_t lead_level;
    level_t next_level;
  } rclk_entry_t;

  // Reduces a value below 60 to a clock position.
  function automatic pos_t mod12(input logic [5:0] q);
    pos_t r;
    if (q >= 6'd48) begin
      r = pos_t'(q - 6'd48);
    end else if (q >= 6'd36) begin
      r = pos_t'(q - 6'd36);
    end else if (q >= 6'd24) begin
      r = pos_t'(q - 6'd24);
    end else if (q >= 6'd12) begin
      r = pos_t'(q - 6'd12);
    end else begin
      r = pos_t'(q);
    end
    return r;
  endfunction

endpackage

[rtl/rclk_front.sv]
module rclk_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rclk_pkg::time_t       time_ms,
  output logic                  push,
  output rclk_pkg::rclk_entry_t push_entry,
  input  logic                  push_ready
);

  localparam logic [1:0] PH_HOUR = 2'd0;
  localparam logic [1:0] PH_MARK = 2'd1;
  localparam logic [1:0] PH_LEAD = 2'd2;
  localparam logic [1:0] PH_FADE = 2'd3;

  logic                 busy;
  logic [1:0]           phase;
  logic [1:0]           dig;
  logic [1:0]           dig_start;
  rclk_pkg::rem_t       rem;
  rclk_pkg::quo_t       quo;
  rclk_pkg::pos_t       hour;
  rclk_pkg::pos_t       mark;
  rclk_pkg::pos_t       lead;

  rclk_pkg::rem_t       base;
  rclk_pkg::rem_t       dsh;
  rclk_pkg::rem_t       c2;
  rclk_pkg::rem_t       c3;
  rclk_pkg::rem_t       sel;
  rclk_pkg::rem_t       rem_sub;
  logic [1:0]           digit;
  rclk_pkg::quo_t       quo_step;
  logic                 last_step;
  logic                 step_en;
  logic                 accept;

  // Divisor for the current phase, shifted to the current radix-4 digit.
  always_comb begin
    case (phase)
      PH_HOUR: base = rclk_pkg::DIV_HOUR;
      PH_MARK: base = rclk_pkg::DIV_MARK;
      PH_LEAD: base = rclk_pkg::DIV_FIVE;
      PH_FADE: base = rclk_pkg::DIV_FADE;
      default: base = rclk_pkg::DIV_FADE;
    endcase
    dsh = base << {dig, 1'b0};
    c2  = dsh << 1;
    c3  = dsh + c2;
  end

  // A radix-4 digit per cycle, last held on a full queue: 3 parallel compares, 1 subtract.
  always_comb begin
    if (rem >= c3) begin
      digit = 2'd3;
      sel   = c3;
    end else if (rem >= c2) begin
      digit = 2'd2;
      sel   = c2;
    end else if (rem >= dsh) begin
      digit = 2'd1;
      sel   = dsh;
    end else begin
      digit = 2'd0;
      sel   = '0;
    end
    rem_sub  = rem - sel;
    quo_step = {quo[5:0], digit};
  end

  // First digit of the phase that follows the current one.
  always_comb begin
    case (phase)
      PH_HOUR: dig_start = 2'd1;
      PH_MARK: dig_start = 2'd2;
      PH_LEAD: dig_start = 2'd3;
      default: dig_start = 2'd2;
    endcase
  end

  // Handshake: a new beat is taken while the last digit of the previous one is handed on.
  assign last_step = busy && (phase == PH_FADE) && (dig == 2'd0);
  assign push      = last_step;
  assign step_en   = busy && (!last_step || push_ready);
  assign in_stall  = busy && !(last_step && push_ready);
  assign accept    = in_valid && !in_stall;

  // The fade quotient gives the trailing level; the leading level is 255 minus its ceiling.
  always_comb begin
    push_entry.hour       = hour;
    push_entry.mark       = mark;
    push_entry.lead       = lead;
    push_entry.next_level = quo_step;
    push_entry.lead_level = rclk_pkg::FULL_LEVEL - quo_step
                            - rclk_pkg::level_t'(rem_sub != '0);
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_HOUR;
      dig   <= 2'd2;
    end else if (accept) begin
      busy  <= 1'b1;
      phase <= PH_HOUR;
      dig   <= 2'd2;
    end else if (step_en) begin
      if (dig == 2'd0) begin
        phase <= phase + 2'd1;
        dig   <= dig_start;
        if (last_step) begin
          busy <= 1'b0;
        end
      end else begin
        dig <= dig - 2'd1;
      end
    end
  end

  // Divider datapath and the positions captured as the hour, mark and lead phases end.
  always_ff @(posedge clk) begin
    if (accept) begin
      rem <= rclk_pkg::rem_t'(time_ms) * rclk_pkg::rem_t'(rclk_pkg::SCALE);
      quo <= '0;
    end else if (step_en) begin
      rem <= rem_sub;
      if (dig == 2'd0) begin
        quo <= '0;
        case (phase)
          PH_HOUR: hour <= rclk_pkg::mod12(quo_step[5:0]);
          PH_MARK: mark <= quo_step[rclk_pkg::POS_W-1:0];
          PH_LEAD: lead <= rclk_pkg::mod12(quo_step[5:0]);
          default: ;
        endcase
      end else begin
        quo <= quo_step;
      end
    end
  end

`ifndef SYNTHESIS
  // The restoring division never leaves a remainder beyond what the open digits can take.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < (dsh << 2)))
    else $error("front: remainder exceeds digit range");

  // Every classified beat carries positions on the clock face.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    push |-> (hour <= rclk_pkg::LAST_POS && mark <= rclk_pkg::LAST_POS
              && lead <= rclk_pkg::LAST_POS))
    else $error("front: position out of range");

  // The sequencer only goes idle after handing a finished beat to the queue.
  a_idle_after_push: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && $past(!rst)) |-> $past(last_step && push_ready))
    else $error("front: went idle without a push");
`endif

endmodule

[rtl/rclk_queue.sv]
module rclk_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rclk_pkg::rclk_entry_t push_entry,
  output logic                  push_ready,
  output logic                  pop_valid,
  output rclk_pkg::rclk_entry_t pop_entry,
  input  logic                  pop
);

  rclk_pkg::rclk_entry_t             mem [rclk_pkg::QDEPTH];
  logic [rclk_pkg::QPTR_W-1:0]       wr_ptr;
  logic [rclk_pkg::QPTR_W-1:0]       rd_ptr;
  logic [rclk_pkg::QCNT_W-1:0]       count;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = (count != rclk_pkg::QCNT_W'(rclk_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_entry  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == rclk_pkg::QPTR_W'(rclk_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rclk_pkg::QPTR_W'(rclk_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  // The back part only retires an entry that is there.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("queue: pop from empty queue");

  // A push that waits on a full queue is held with its entry unchanged.
  a_push_held: assert property (@(posedge clk) disable iff (rst)
    (push && !push_ready) |=> (push && $stable(push_entry)))
    else $error("queue: waiting push dropped or changed");

  // Pointers stay consistent with the fill count.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == rclk_pkg::QCNT_W'(rclk_pkg::QDEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue: pointers disagree with count");
`endif

endmodule

[rtl/rclk_back.sv]
module rclk_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  input  rclk_pkg::rclk_entry_t pop_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rclk_pkg::pos_t        led_index,
  output rclk_pkg::level_t      outer_level,
  output rclk_pkg::level_t      inner_level,
  output logic                  last
);

  rclk_pkg::pos_t   pos;
  rclk_pkg::pos_t   next_pos;
  rclk_pkg::level_t inner_val;
  rclk_pkg::level_t outer_val;
  logic             adv;
  logic             load;

  // The output register moves on whenever it is empty or being taken.
  assign adv  = !out_valid || !out_stall;
  assign load = adv && pop_valid;
  assign pop  = load && (pos == rclk_pkg::LAST_POS);

  // Levels for the position being emitted; the minute mark wins over the fade.
  always_comb begin
    next_pos = (pop_entry.lead == rclk_pkg::LAST_POS) ? '0 : pop_entry.lead + 1'b1;
    if (pos == pop_entry.mark) begin
      inner_val = rclk_pkg::FULL_LEVEL;
    end else if (pos == pop_entry.lead) begin
      inner_val = pop_entry.lead_level;
    end else if (pos == next_pos) begin
      inner_val = pop_entry.next_level;
    end else begin
      inner_val = '0;
    end
    outer_val = (pos == pop_entry.hour) ? rclk_pkg::FULL_LEVEL : '0;
  end

  // Position counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (adv) begin
      out_valid <= pop_valid;
      if (pop_valid) begin
        pos <= (pos == rclk_pkg::LAST_POS) ? '0 : pos + 1'b1;
      end
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (load) begin
      led_index   <= pos;
      outer_level <= outer_val;
      inner_level <= inner_val;
      last        <= (pos == rclk_pkg::LAST_POS);
    end
  end

`ifndef SYNTHESIS
  // The closing beat of a run sits at the last clock position.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (led_index == rclk_pkg::LAST_POS))
    else $error("back: last flag away from last position");

  // An entry is retired only once all twelve positions are out.
  a_pop_at_end: assert property (@(posedge clk) disable iff (rst)
    pop |-> (pos == rclk_pkg::LAST_POS))
    else $error("back: entry retired early");

  // A run always starts at twelve o'clock.
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && $past(!rst)) |-> (led_index == '0))
    else $error("back: run does not start at position zero");
`endif

endmodule

[rtl/ring_clock_led_levels.sv]
// Channel   Handshake              Beat contents
// input     in_valid / in_stall    time_ms
// output    out_valid / out_stall  led_index, outer_level, inner_level, last
//
// Each time value yields twelve output beats, positions 0 to 11, last set on the twelfth.
// Sustained throughput is bounded both by the twelve radix-4 digit steps of the shared
// divider in the front part and by the twelve beats of the back part. The first beat of
// a value goes through the divider, the queue and the output register of the back part.
// A two-entry queue lets the divider run ahead while the output is stalled.
// Reset is synchronous and active high; it empties the queue and idles both parts.
module ring_clock_led_levels (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [25:0]               time_ms,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                led_index,
  output logic [7:0]                outer_level,
  output logic [7:0]                inner_level,
  output logic                      last
);

  logic                  push;
  logic                  push_ready;
  rclk_pkg::rclk_entry_t push_entry;
  logic                  pop;
  logic                  pop_valid;
  rclk_pkg::rclk_entry_t pop_entry;

  // Front part: splits the time and works out the fade levels.
  rclk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .time_ms    (time_ms),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Queue between the two parts.
  rclk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  // Back part: walks the twelve positions.
  rclk_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .led_index   (led_index),
    .outer_level (outer_level),
    .inner_level (inner_level),
    .last        (last)
  );

endmodule
